[hw/rtl/tse_pkg.sv]
// ----------------------------------------------------------------------------
// tse_pkg: shared types, constants and arithmetic helpers
// Fixed-point format, series-step constants, saturation and rounding helpers
// and the constant reciprocal table used by the series step pipeline.
// ----------------------------------------------------------------------------
package tse_pkg;

  localparam int TERMS     = 8;
  localparam int FRAC_BITS = 24;

  // Pipeline registers inside one series step.
  localparam int STEP_STAGES = 10;

  localparam int STEP_W  = $clog2(TERMS);
  localparam int DEN_MAX = (2 * TERMS - 2) * (2 * TERMS - 1);
  localparam int DEN_W   = $clog2(DEN_MAX + 1);
  localparam int N_W     = 32 + STEP_W;
  localparam int R_W     = N_W + 1;
  localparam int RL_W    = R_W / 2;
  localparam int RH_W    = R_W - RL_W;

  localparam logic signed [31:0] FX_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] FX_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] FX_ONE = 32'(64'd1 << FRAC_BITS);
  localparam logic [63:0] RND_HALF = 64'd1 << (FRAC_BITS - 1);
  localparam logic [63:0] MAG_MIN  = 64'h0000_0000_8000_0000;
  localparam logic [63:0] MAG_MAX  = 64'h0000_0000_7fff_ffff;

  typedef enum logic [1:0] {
    MODE_SIN = 2'd0,
    MODE_COS = 2'd1,
    MODE_EXP = 2'd2,
    MODE_LN  = 2'd3
  } tse_mode_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               ov;
  } tse_sat_t;

  typedef struct packed {
    tse_mode_t          mode;
    logic signed [31:0] x;
    logic signed [31:0] sum;
    logic               ov;
  } tse_ctx_t;

  typedef struct packed {
    tse_ctx_t           ctx;
    logic signed [31:0] term;
  } tse_item_t;

  typedef struct packed {
    logic signed [31:0] y;
    logic               ov;
  } tse_res_t;

  typedef logic [3:0][TERMS-1:0][R_W-1:0] tse_recip_tbl_t;

  // Clamp a sign and magnitude pair into the 32-bit signed range.
  function automatic tse_sat_t sat_mag(input logic neg, input logic [63:0] mag);
    tse_sat_t r;
    r.ov = 1'b0;
    if (neg) begin
      if (mag > MAG_MIN) begin
        r.val = FX_MIN;
        r.ov  = 1'b1;
      end else begin
        r.val = ~mag[31:0] + 32'd1;
      end
    end else if (mag > MAG_MAX) begin
      r.val = FX_MAX;
      r.ov  = 1'b1;
    end else begin
      r.val = mag[31:0];
    end
    return r;
  endfunction

  // Fixed-point rescale of a full product, rounded half away from zero.
  // For a negative product, ~p is the magnitude minus one, so the rounding
  // constant carries the extra one and a single adder does both jobs.
  function automatic tse_sat_t rnd_sat(input logic signed [63:0] p);
    logic        neg;
    logic [63:0] base;
    logic [63:0] mag;
    neg  = p[63];
    base = neg ? 64'(~p) : 64'(p);
    mag  = base + (neg ? RND_HALF + 64'd1 : RND_HALF);
    return sat_mag(neg, mag >> FRAC_BITS);
  endfunction

  // Saturating 32-bit signed addition.
  function automatic tse_sat_t sat_add(input logic signed [31:0] a,
                                       input logic signed [31:0] b);
    tse_sat_t           r;
    logic signed [32:0] s;
    s    = {a[31], a} + {b[31], b};
    r.ov = s[32] != s[31];
    if (r.ov) begin
      r.val = s[32] ? FX_MIN : FX_MAX;
    end else begin
      r.val = s[31:0];
    end
    return r;
  endfunction

  // Divisor of the term ratio for a given function and step index.
  function automatic logic [DEN_W-1:0] den_of(input tse_mode_t m,
                                              input logic [STEP_W-1:0] i);
    logic [DEN_W-1:0] k;
    logic [DEN_W-1:0] d;
    k = DEN_W'(i);
    if (i == '0) begin
      d = DEN_W'(1);
    end else begin
      case (m)
        MODE_SIN: d = (k << 1) * ((k << 1) + DEN_W'(1));
        MODE_COS: d = (k << 1) * ((k << 1) - DEN_W'(1));
        MODE_EXP: d = k;
        MODE_LN:  d = k + DEN_W'(1);
        default:  d = DEN_W'(1);
      endcase
    end
    return d;
  endfunction

  // Reciprocal table, floor(2^N_W / den), built by restoring long division
  // at elaboration.
  function automatic tse_recip_tbl_t build_recip();
    tse_recip_tbl_t   tbl;
    logic [R_W-1:0]   q;
    logic [DEN_W:0]   rem;
    logic [DEN_W-1:0] d;
    tbl = '0;
    for (int m = 0; m < 4; m++) begin
      for (int i = 0; i < TERMS; i++) begin
        d   = den_of(tse_mode_t'(m), STEP_W'(i));
        rem = '0;
        q   = '0;
        for (int b = N_W; b >= 0; b--) begin
          rem = {rem[DEN_W-1:0], (b == N_W)};
          if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[b] = 1'b1;
          end
        end
        tbl[m][i] = q;
      end
    end
    return tbl;
  endfunction

  localparam tse_recip_tbl_t RECIP_TBL = build_recip();

endpackage

[hw/rtl/tse_step.sv]
// ----------------------------------------------------------------------------
// tse_step: one series step
// Adds the current term to the running sum and derives the next term through
// fixed-point products and a rounded division by a constant.
// ----------------------------------------------------------------------------
module tse_step
  import tse_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [STEP_W-1:0] step,
  input  logic              in_v,
  input  tse_item_t         in_item,
  output logic              out_v,
  output tse_item_t         out_item
);

  logic [STEP_STAGES-1:0] v_r;

  tse_ctx_t ctx1_r, ctx2_r, ctx3_r, ctx4_r, ctx5_r;
  tse_ctx_t ctx6_r, ctx7_r, ctx8_r, ctx9_r, ctx10_r;
  tse_ctx_t ctx1_nxt, ctx2_nxt, ctx4_nxt, ctx10_nxt;

  logic signed [63:0] p1_r, p1_nxt, p3_r, p3_nxt;
  logic signed [31:0] a2_r, a3_r, v4_r, v4_nxt, term10_r;
  logic [N_W-1:0]     n5_r, n6_r, n7_r, n8_r, n5_nxt;
  logic               neg5_r, neg6_r, neg7_r, neg8_r, neg9_r, neg5_nxt;
  logic [N_W+RH_W-1:0] ph6_r, ph6_nxt;
  logic [N_W+RL_W-1:0] pl6_r, pl6_nxt;
  logic [N_W-1:0]     qe7_r, qe8_r, qd8_r, q9_r, qe7_nxt, qd8_nxt, q9_nxt;

  tse_sat_t           s1_sum, r2, r4, t10;
  logic               sc4;
  logic [31:0]        mag5;
  logic [STEP_W-1:0]  num5;
  logic [DEN_W-1:0]   den5, den8, den9;
  logic [R_W-1:0]     rc6;
  logic [N_W+R_W-1:0] acc7;
  logic [N_W-1:0]     r9;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STEP_STAGES-2:0], in_v};
    end
  end

  always_comb begin
    // Stage 1: accumulate the current term, first product term * x.
    s1_sum       = sat_add(in_item.ctx.sum, in_item.term);
    ctx1_nxt     = in_item.ctx;
    ctx1_nxt.sum = s1_sum.val;
    ctx1_nxt.ov  = in_item.ctx.ov | s1_sum.ov;
    p1_nxt       = $signed(in_item.term) * $signed(in_item.ctx.x);

    // Stage 2: round the first product.
    r2          = rnd_sat(p1_r);
    ctx2_nxt    = ctx1_r;
    ctx2_nxt.ov = ctx1_r.ov | r2.ov;

    // Stage 3: second product, needed only by sin and cos.
    p3_nxt = $signed(a2_r) * $signed(ctx2_r.x);

    // Stage 4: round the second product and pick the dividend.
    r4          = rnd_sat(p3_r);
    sc4         = (ctx3_r.mode == MODE_SIN) || (ctx3_r.mode == MODE_COS);
    v4_nxt      = sc4 ? r4.val : a3_r;
    ctx4_nxt    = ctx3_r;
    ctx4_nxt.ov = ctx3_r.ov | (sc4 & r4.ov);

    // Stage 5: magnitude times numerator plus half the divisor.
    mag5     = v4_r[31] ? (32'(~v4_r) + 32'd1) : 32'(v4_r);
    num5     = (ctx4_r.mode == MODE_LN) ? step : STEP_W'(1);
    den5     = den_of(ctx4_r.mode, step);
    n5_nxt   = N_W'(mag5) * N_W'(num5) + N_W'(den5 >> 1);
    neg5_nxt = v4_r[31] ^ (ctx4_r.mode != MODE_EXP);

    // Stage 6: partial products against the reciprocal.
    rc6     = RECIP_TBL[ctx5_r.mode][step];
    ph6_nxt = (N_W+RH_W)'(n5_r) * (N_W+RH_W)'(rc6[R_W-1:RL_W]);
    pl6_nxt = (N_W+RL_W)'(n5_r) * (N_W+RL_W)'(rc6[RL_W-1:0]);

    // Stage 7: combine the partial products into a quotient estimate,
    // which is the true quotient or one less.
    acc7    = {ph6_r, {RL_W{1'b0}}} + (N_W+R_W)'(pl6_r);
    qe7_nxt = acc7[N_W +: N_W];

    // Stage 8: estimate times divisor.
    den8    = den_of(ctx7_r.mode, step);
    qd8_nxt = qe7_r * N_W'(den8);

    // Stage 9: correct the estimate from the remainder.
    den9   = den_of(ctx8_r.mode, step);
    r9     = n8_r - qd8_r;
    q9_nxt = qe8_r + N_W'(r9[DEN_W:0] >= {1'b0, den9});

    // Stage 10: apply the sign and saturate the new term.
    t10          = sat_mag(neg9_r && (q9_r != '0), 64'(q9_r));
    ctx10_nxt    = ctx9_r;
    ctx10_nxt.ov = ctx9_r.ov | t10.ov;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx1_r   <= ctx1_nxt;
      p1_r     <= p1_nxt;
      ctx2_r   <= ctx2_nxt;
      a2_r     <= r2.val;
      ctx3_r   <= ctx2_r;
      a3_r     <= a2_r;
      p3_r     <= p3_nxt;
      ctx4_r   <= ctx4_nxt;
      v4_r     <= v4_nxt;
      ctx5_r   <= ctx4_r;
      n5_r     <= n5_nxt;
      neg5_r   <= neg5_nxt;
      ctx6_r   <= ctx5_r;
      n6_r     <= n5_r;
      neg6_r   <= neg5_r;
      ph6_r    <= ph6_nxt;
      pl6_r    <= pl6_nxt;
      ctx7_r   <= ctx6_r;
      n7_r     <= n6_r;
      neg7_r   <= neg6_r;
      qe7_r    <= qe7_nxt;
      ctx8_r   <= ctx7_r;
      n8_r     <= n7_r;
      neg8_r   <= neg7_r;
      qe8_r    <= qe7_r;
      qd8_r    <= qd8_nxt;
      ctx9_r   <= ctx8_r;
      neg9_r   <= neg8_r;
      q9_r     <= q9_nxt;
      ctx10_r  <= ctx10_nxt;
      term10_r <= t10.val;
    end
  end

  assign out_v         = v_r[STEP_STAGES-1];
  assign out_item.ctx  = ctx10_r;
  assign out_item.term = term10_r;

endmodule

[hw/rtl/tse_outbuf.sv]
// ----------------------------------------------------------------------------
// tse_outbuf: two-entry output buffer
// Holds the result register and a skid entry so that the pipeline keeps
// moving while a result waits to be taken.
// ----------------------------------------------------------------------------
module tse_outbuf
  import tse_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fin_v,
  input  tse_res_t fin,
  output logic     en,
  output logic     out_valid,
  input  logic     out_ready,
  output tse_res_t out_res
);

  logic     out_v_r, skid_v_r, out_v_nxt, skid_v_nxt;
  logic     load_out, load_skid, out_from_skid;
  tse_res_t out_r, skid_r;

  assign en = !skid_v_r;

  always_comb begin
    out_v_nxt     = out_v_r;
    skid_v_nxt    = skid_v_r;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    out_from_skid = 1'b0;
    if (skid_v_r) begin
      if (out_ready) begin
        load_out      = 1'b1;
        out_from_skid = 1'b1;
        skid_v_nxt    = 1'b0;
      end
    end else if (fin_v) begin
      if (!out_v_r || out_ready) begin
        load_out  = 1'b1;
        out_v_nxt = 1'b1;
      end else begin
        load_skid  = 1'b1;
        skid_v_nxt = 1'b1;
      end
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= out_from_skid ? skid_r : fin;
    end
    if (load_skid) begin
      skid_r <= fin;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;

endmodule

[hw/rtl/taylor_series_evaluator.sv]
// ----------------------------------------------------------------------------
// taylor_series_evaluator: truncated Taylor series of sin, cos, exp, ln(1+x)
// Path from input to output: ten register stages per series step, a final sum
// stage and the output register; the steps are fully pipelined.
// Throughput: one transaction per cycle while the output skid entry is empty.
// Reset clears all valid bits and the output buffer; no clearing pass.
// ----------------------------------------------------------------------------
module taylor_series_evaluator
  import tse_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_x,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_y,
  output logic               out_overflow
);

  // The whole datapath advances on one enable. The output buffer drops it
  // only when both its result register and its skid entry are full, so a
  // waiting result never blocks the input by itself.
  logic      en;

  // Item chain between the series steps. Entry 0 is the raw input
  // transaction with its first term: x for sin and ln(1+x), one for cos and
  // exp. The sum starts at zero with a clear overflow flag.
  logic      chain_v [TERMS];
  tse_item_t chain   [TERMS];

  always_comb begin
    chain_v[0]          = in_valid;
    chain[0].ctx.mode   = tse_mode_t'(in_mode);
    chain[0].ctx.x      = in_x;
    chain[0].ctx.sum    = '0;
    chain[0].ctx.ov     = 1'b0;
    chain[0].term       = ((tse_mode_t'(in_mode) == MODE_SIN) ||
                           (tse_mode_t'(in_mode) == MODE_LN)) ? in_x : FX_ONE;
  end

  // One step per ratio: step i adds term i-1 to the sum and produces term i.
  for (genvar g = 0; g < TERMS - 1; g++) begin : g_step
    tse_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .step     (STEP_W'(g + 1)),
      .in_v     (chain_v[g]),
      .in_item  (chain[g]),
      .out_v    (chain_v[g+1]),
      .out_item (chain[g+1])
    );
  end

  // Final stage: the last term is added with no ratio after it, so it can
  // only flag overflow through the sum itself.
  tse_sat_t fin_sum;
  tse_res_t fin_r, fin_nxt;
  logic     fin_v_r;

  always_comb begin
    fin_sum    = sat_add(chain[TERMS-1].ctx.sum, chain[TERMS-1].term);
    fin_nxt.y  = fin_sum.val;
    fin_nxt.ov = chain[TERMS-1].ctx.ov | fin_sum.ov;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= chain_v[TERMS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_r <= fin_nxt;
    end
  end

  tse_res_t out_res;

  tse_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin_v     (fin_v_r),
    .fin       (fin_r),
    .en        (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign in_ready     = en;
  assign out_y        = out_res.y;
  assign out_overflow = out_res.ov;

  // The input can only be held off while a result is being presented.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // A full skid entry empties in the next cycle once a result is taken.
  a_stall_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_ready && out_ready) |=> in_ready)
    else $error("input stall outlived a result transaction");

  // A finished sum with room at the output is presented in the next cycle.
  a_fin_presented: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_v_r && in_ready && (!out_valid || out_ready)) |=> out_valid)
    else $error("finished sum was not presented");

endmodule
